// ===== sv/hwel_pkg.sv =====
// Shared types and constants for the heartbeat watchdog event log.
package hwel_pkg;

    localparam int LOG_DEPTH_DEFAULT = 16;
    localparam logic [31:0] TIMEOUT_RESET = 32'd1000;

    localparam int IDX_W = 8;
    localparam int S_TDATA_W = 72;
    localparam int M_TDATA_W = 296;
    localparam int HELD_W = 5;
    localparam int CODE_W = 3;

    // Action carried in the input tuser field.
    typedef enum logic [2:0] {
        ACT_TICK      = 3'd0,
        ACT_UPDATE    = 3'd1,
        ACT_REJECT    = 3'd2,
        ACT_PROTO_ERR = 3'd3,
        ACT_READ      = 3'd4,
        ACT_CLEAR     = 3'd5
    } action_t;

    // Entry kinds as stored in the log.
    localparam logic [1:0] KIND_TIMEOUT   = 2'd0;
    localparam logic [1:0] KIND_UPDATE    = 2'd1;
    localparam logic [1:0] KIND_REJECT    = 2'd2;
    localparam logic [1:0] KIND_PROTO_ERR = 2'd3;

    // Entry code reported when a request reads nothing.
    localparam logic [CODE_W-1:0] CODE_NONE = 3'd4;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] stamp;
        logic [31:0] argument;
    } log_entry_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_FINISH
    } ctrl_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic execute;
        logic load_result;
    } ctrl_cmd_t;

endpackage

// ===== sv/heartbeat_watchdog_event_log.sv =====
// Top level of the heartbeat watchdog event log.
//
// This block takes one request at a time and answers each with exactly one
// result. A request is accepted, then executed (the watchdog and counter
// update, plus either the append to the ring log or the address phase of a
// log read), and then the log memory's read data is registered into the
// result register; the registered read port of the log memory is what needs
// that final step. A finished result waits in its own output register, so
// the next request is accepted and executed while the previous result is
// still unclaimed; only a second result with the first still waiting holds
// the block in its result cycle. The watchdog timeout register may be
// written at any time the block is idle and resets to 1000.
// The log keeps LOG_DEPTH entries, overwrites the oldest entry when full and
// counts each overwrite. Log storage is not cleared on reset or by a clear
// request; the fill count makes unwritten entries unreachable.
module heartbeat_watchdog_event_log
    import hwel_pkg::*;
#(
    parameter int LOG_DEPTH = LOG_DEPTH_DEFAULT
) (
    input  logic                 aclk,
    input  logic                 aresetn,

    // Watchdog timeout in milliseconds.
    input  logic                 cfg_wr_en,
    input  logic [31:0]          cfg_wr_data,

    input  logic                 s_tvalid,
    output logic                 s_tready,
    // stamp_ms[31:0], event_value[63:32], log_index[71:64]
    input  logic [S_TDATA_W-1:0] s_tdata,
    // action[2:0]
    input  logic [CODE_W-1:0]    s_tuser,

    output logic                 m_tvalid,
    input  logic                 m_tready,
    // entries_held[4:0], entries_dropped[36:5], revision_count[68:37],
    // heartbeats_seen[100:69], healthy[101], watchdog_trip_count[133:102],
    // update_count[165:134], rejection_count[197:166],
    // protocol_error_count[229:198], entry_time[261:230],
    // entry_argument[293:262], zero padding[295:294]
    output logic [M_TDATA_W-1:0] m_tdata,
    // entry_code[2:0]
    output logic [CODE_W-1:0]    m_tuser
);

    // Commands flow from the controller into the datapath; the datapath needs
    // nothing back because every request follows the same three-step path.
    ctrl_cmd_t cmd;

    hwel_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    hwel_datapath #(
        .LOG_DEPTH (LOG_DEPTH)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd         (cmd),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

endmodule

// ===== sv/hwel_log_ram.sv =====
// Ring log storage: one write port, one registered read port.
module hwel_log_ram
    import hwel_pkg::*;
#(
    parameter int DEPTH = LOG_DEPTH_DEFAULT,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  log_entry_t        wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output log_entry_t        rd_data
);

    log_entry_t mem [DEPTH];
    log_entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sv/hwel_ctrl.sv =====
// Controller state machine: accept, execute and result sequencing.
module hwel_ctrl
    import hwel_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    output logic      s_tready,
    output logic      m_tvalid,
    input  logic      m_tready,
    output ctrl_cmd_t cmd
);

    ctrl_state_t state_reg, state_next;
    logic        m_valid_reg, m_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next  = state_reg;
        s_tready    = 1'b0;
        cmd         = '0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC: begin
                cmd.execute = 1'b1;
                state_next  = ST_FINISH;
            end
            ST_FINISH: begin
                // The result register must be empty or emptying this cycle.
                if (!m_valid_reg || m_tready) begin
                    cmd.load_result = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (cmd.load_result) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    assign m_tvalid = m_valid_reg;

endmodule

// ===== sv/hwel_datapath.sv =====
// Datapath: watchdog state, status counters, ring log pointers and result register.
module hwel_datapath
    import hwel_pkg::*;
#(
    parameter int LOG_DEPTH = LOG_DEPTH_DEFAULT
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [31:0]          cfg_wr_data,
    input  ctrl_cmd_t            cmd,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic [CODE_W-1:0]    s_tuser,
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic [CODE_W-1:0]    m_tuser
);

    localparam int SLOT_W  = $clog2(LOG_DEPTH);
    localparam int COUNT_W = $clog2(LOG_DEPTH + 1);
    localparam int WSUM_W  = COUNT_W + 1;
    localparam int CMP_W   = (COUNT_W > IDX_W) ? COUNT_W : IDX_W;
    localparam int RSUM_W  = CMP_W + 1;

    // Captured request.
    action_t            action_reg;
    logic [31:0]        stamp_reg;
    logic [31:0]        value_reg;
    logic [IDX_W-1:0]   index_reg;

    logic [31:0]        timeout_reg;

    logic [SLOT_W-1:0]  oldest_reg, oldest_next;
    logic [COUNT_W-1:0] held_reg, held_next;
    logic [31:0]        last_beat_reg, last_beat_next;
    logic               armed_reg, armed_next;
    logic               healthy_reg, healthy_next;
    logic [31:0]        dropped_reg, dropped_next;
    logic [31:0]        revision_reg, revision_next;
    logic [31:0]        beats_reg, beats_next;
    logic [31:0]        trips_reg, trips_next;
    logic [31:0]        updates_reg, updates_next;
    logic [31:0]        rejects_reg, rejects_next;
    logic [31:0]        proto_errs_reg, proto_errs_next;
    logic               hit_reg, hit_next;

    logic [M_TDATA_W-1:0] out_data_reg;
    logic [CODE_W-1:0]    out_code_reg;

    logic [31:0]        elapsed;
    logic               late;
    logic               push;
    logic [1:0]         push_kind;
    logic [31:0]        push_arg;
    logic               full;
    logic [WSUM_W-1:0]  wsum;
    logic [SLOT_W-1:0]  wr_slot;
    logic [RSUM_W-1:0]  rsum;
    logic [SLOT_W-1:0]  rd_slot;
    logic               read_hit;
    log_entry_t         wr_entry;
    log_entry_t         rd_entry;

    hwel_log_ram #(
        .DEPTH (LOG_DEPTH)
    ) u_log_ram (
        .aclk    (aclk),
        .wr_en   (push && cmd.execute),
        .wr_addr (wr_slot),
        .wr_data (wr_entry),
        .rd_addr (rd_slot),
        .rd_data (rd_entry)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg <= TIMEOUT_RESET;
        end else if (cfg_wr_en) begin
            timeout_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            action_reg <= action_t'(s_tuser);
            stamp_reg  <= s_tdata[31:0];
            value_reg  <= s_tdata[63:32];
            index_reg  <= s_tdata[71:64];
        end
    end

    // Pointer and slot arithmetic; the write-slot sum stays below twice the depth.
    always_comb begin
        elapsed  = stamp_reg - last_beat_reg;
        late     = elapsed > timeout_reg;
        full     = held_reg == COUNT_W'(LOG_DEPTH);
        wsum     = WSUM_W'(oldest_reg) + WSUM_W'(held_reg);
        if (wsum >= WSUM_W'(LOG_DEPTH)) begin
            wsum = wsum - WSUM_W'(LOG_DEPTH);
        end
        // When full, the new entry lands on the oldest slot.
        wr_slot  = full ? oldest_reg : wsum[SLOT_W-1:0];
        rsum     = RSUM_W'(oldest_reg) + RSUM_W'(index_reg);
        if (rsum >= RSUM_W'(LOG_DEPTH)) begin
            rsum = rsum - RSUM_W'(LOG_DEPTH);
        end
        rd_slot  = rsum[SLOT_W-1:0];
        read_hit = CMP_W'(index_reg) < CMP_W'(held_reg);
    end

    always_comb begin
        oldest_next     = oldest_reg;
        held_next       = held_reg;
        last_beat_next  = last_beat_reg;
        armed_next      = armed_reg;
        healthy_next    = healthy_reg;
        dropped_next    = dropped_reg;
        revision_next   = revision_reg;
        beats_next      = beats_reg;
        trips_next      = trips_reg;
        updates_next    = updates_reg;
        rejects_next    = rejects_reg;
        proto_errs_next = proto_errs_reg;
        hit_next        = hit_reg;
        push            = 1'b0;
        push_kind       = KIND_TIMEOUT;
        push_arg        = value_reg;

        if (cmd.execute) begin
            hit_next = 1'b0;
            case (action_reg)
                ACT_TICK: begin
                    if (!armed_reg) begin
                        armed_next     = 1'b1;
                        last_beat_next = stamp_reg;
                        beats_next     = 32'd1;
                        healthy_next   = 1'b1;
                        revision_next  = revision_reg + 32'd1;
                    end else if (stamp_reg != last_beat_reg) begin
                        last_beat_next = stamp_reg;
                        beats_next     = beats_reg + 32'd1;
                        healthy_next   = !late;
                        if (late) begin
                            trips_next = trips_reg + 32'd1;
                            push       = 1'b1;
                            push_kind  = KIND_TIMEOUT;
                            push_arg   = elapsed;
                        end else begin
                            revision_next = revision_reg + 32'd1;
                        end
                    end
                end
                ACT_UPDATE: begin
                    updates_next = updates_reg + 32'd1;
                    push         = 1'b1;
                    push_kind    = KIND_UPDATE;
                end
                ACT_REJECT: begin
                    rejects_next = rejects_reg + 32'd1;
                    push         = 1'b1;
                    push_kind    = KIND_REJECT;
                end
                ACT_PROTO_ERR: begin
                    proto_errs_next = proto_errs_reg + 32'd1;
                    push            = 1'b1;
                    push_kind       = KIND_PROTO_ERR;
                end
                ACT_READ: begin
                    hit_next = read_hit;
                end
                ACT_CLEAR: begin
                    oldest_next     = '0;
                    held_next       = '0;
                    last_beat_next  = '0;
                    armed_next      = 1'b0;
                    healthy_next    = 1'b0;
                    dropped_next    = '0;
                    revision_next   = '0;
                    beats_next      = '0;
                    trips_next      = '0;
                    updates_next    = '0;
                    rejects_next    = '0;
                    proto_errs_next = '0;
                end
                default: begin
                end
            endcase

            if (push) begin
                revision_next = revision_reg + 32'd1;
                if (full) begin
                    oldest_next  = (oldest_reg == SLOT_W'(LOG_DEPTH - 1)) ?
                                   '0 : oldest_reg + SLOT_W'(1);
                    dropped_next = dropped_reg + 32'd1;
                end else begin
                    held_next = held_reg + COUNT_W'(1);
                end
            end
        end
    end

    assign wr_entry = '{kind: push_kind, stamp: stamp_reg, argument: push_arg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            oldest_reg     <= '0;
            held_reg       <= '0;
            last_beat_reg  <= '0;
            armed_reg      <= 1'b0;
            healthy_reg    <= 1'b0;
            dropped_reg    <= '0;
            revision_reg   <= '0;
            beats_reg      <= '0;
            trips_reg      <= '0;
            updates_reg    <= '0;
            rejects_reg    <= '0;
            proto_errs_reg <= '0;
            hit_reg        <= 1'b0;
        end else begin
            oldest_reg     <= oldest_next;
            held_reg       <= held_next;
            last_beat_reg  <= last_beat_next;
            armed_reg      <= armed_next;
            healthy_reg    <= healthy_next;
            dropped_reg    <= dropped_next;
            revision_reg   <= revision_next;
            beats_reg      <= beats_next;
            trips_reg      <= trips_next;
            updates_reg    <= updates_next;
            rejects_reg    <= rejects_next;
            proto_errs_reg <= proto_errs_next;
            hit_reg        <= hit_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_result) begin
            out_data_reg <= {2'b00,
                             hit_reg ? rd_entry.argument : 32'd0,
                             hit_reg ? rd_entry.stamp : 32'd0,
                             proto_errs_reg, rejects_reg, updates_reg, trips_reg,
                             healthy_reg, beats_reg, revision_reg, dropped_reg,
                             HELD_W'(held_reg)};
            out_code_reg <= hit_reg ? {1'b0, rd_entry.kind} : CODE_NONE;
        end
    end

    assign m_tdata = out_data_reg;
    assign m_tuser = out_code_reg;

`ifndef SYNTHESIS
    assert property (@(posedge aclk) disable iff (!aresetn)
        held_reg <= COUNT_W'(LOG_DEPTH))
        else $error("log fill count exceeds depth");

    assert property (@(posedge aclk) disable iff (!aresetn)
        oldest_reg <= SLOT_W'(LOG_DEPTH - 1))
        else $error("oldest slot out of range");

    assert property (@(posedge aclk) disable iff (!aresetn)
        !cmd.execute |=> $stable(revision_reg) && $stable(held_reg))
        else $error("log state changed outside an execute cycle");

    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.execute && action_reg == ACT_CLEAR |=> held_reg == '0 && !armed_reg)
        else $error("clear did not empty the log");

    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.execute && push && !full |=> held_reg == $past(held_reg) + COUNT_W'(1))
        else $error("append did not grow the log");
`endif

endmodule

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the heartbeat watchdog event log.
`timescale 1ns / 1ps

module tb;
    import hwel_pkg::*;

    // The two action encodings that the block must accept and ignore.
    localparam logic [2:0] ACT_RSVD_A = 3'd6;
    localparam logic [2:0] ACT_RSVD_B = 3'd7;

    localparam int RING_DEPTH = LOG_DEPTH_DEFAULT;
    // Covers a request's passage through the block, plus margin.
    localparam int PIPE_CYCLES = 4;
    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_OFF_CYCLES = 80;

    // Everything that one result carries, in unpacked form.
    typedef struct {
        logic [4:0]  held;
        logic [31:0] dropped;
        logic [31:0] revision;
        logic [31:0] beats;
        logic        healthy;
        logic [31:0] trips;
        logic [31:0] updates;
        logic [31:0] rejects;
        logic [31:0] proto_errs;
        logic [2:0]  code;
        logic [31:0] etime;
        logic [31:0] earg;
    } status_t;

    logic                 aclk;
    logic                 aresetn = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [31:0]          cfg_wr_data = '0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [CODE_W-1:0]    s_tuser = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [CODE_W-1:0]    m_tuser;

    heartbeat_watchdog_event_log u_dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

    // Mirror of the block's state. It advances once for every accepted
    // request, at the same clock edge as the block sees the request.
    logic [31:0] ring_stamp [RING_DEPTH];
    logic [1:0]  ring_kind [RING_DEPTH];
    logic [31:0] ring_arg [RING_DEPTH];
    int          ring_head;
    int          ring_fill;
    logic [31:0] prev_beat;
    logic        wd_armed;
    logic        wd_healthy;
    logic [31:0] wd_timeout;
    logic [31:0] drop_cnt;
    logic [31:0] rev_cnt;
    logic [31:0] beat_cnt;
    logic [31:0] trip_cnt;
    logic [31:0] upd_cnt;
    logic [31:0] rej_cnt;
    logic [31:0] perr_cnt;

    // Results that the block still owes us, oldest first.
    status_t pending_status[$];

    int fail_count = 0;
    int cycle_count = 0;
    int act_tally [8];
    int trips_tally = 0;
    int drops_tally = 0;
    int results_checked = 0;
    int timeout_settings = 0;

    // Stimulus knobs shared by the test tasks and the two handshake sides.
    logic        src_idle_en = 1'b1;
    logic        snk_idle_en = 1'b1;
    int          hold_off_req = 0;
    logic [31:0] beat_ms = '0;
    logic [31:0] cur_timeout = TIMEOUT_RESET;

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    always @(posedge aclk) cycle_count <= cycle_count + 1;

    // Hard stop in case the block wedges and a handshake never completes.
    initial begin : run_limit
        wait (cycle_count >= CYCLE_LIMIT);
        $display("tb: FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Clear brings back every piece of state except the timeout register.
    function automatic void wipe_state();
        for (int i = 0; i < RING_DEPTH; i++) begin
            ring_stamp[i] = '0;
            ring_kind[i] = KIND_TIMEOUT;
            ring_arg[i] = '0;
        end
        ring_head = 0;
        ring_fill = 0;
        prev_beat = '0;
        wd_armed = 1'b0;
        wd_healthy = 1'b0;
        drop_cnt = '0;
        rev_cnt = '0;
        beat_cnt = '0;
        trip_cnt = '0;
        upd_cnt = '0;
        rej_cnt = '0;
        perr_cnt = '0;
    endfunction

    // Appending to a full ring pushes the oldest entry out and counts it.
    function automatic void log_append(logic [31:0] stamp, logic [1:0] kind,
                                       logic [31:0] arg);
        int slot;
        if (ring_fill >= RING_DEPTH) begin
            ring_head = (ring_head + 1) % RING_DEPTH;
            ring_fill = RING_DEPTH - 1;
            drop_cnt = drop_cnt + 1;
            drops_tally++;
        end
        slot = (ring_head + ring_fill) % RING_DEPTH;
        ring_stamp[slot] = stamp;
        ring_kind[slot] = kind;
        ring_arg[slot] = arg;
        ring_fill++;
        rev_cnt = rev_cnt + 1;
    endfunction

    function automatic void heartbeat(logic [31:0] stamp);
        logic [31:0] elapsed;
        if (!wd_armed) begin
            // The first heartbeat arms the watchdog; it is not checked against the timeout.
            wd_armed = 1'b1;
            prev_beat = stamp;
            beat_cnt = 32'd1;
            wd_healthy = 1'b1;
            rev_cnt = rev_cnt + 1;
        end else if (stamp != prev_beat) begin
            // Elapsed time is taken modulo 2^32, so a timestamp wrap is fine.
            elapsed = stamp - prev_beat;
            prev_beat = stamp;
            beat_cnt = beat_cnt + 1;
            wd_healthy = (elapsed <= wd_timeout);
            if (!wd_healthy) begin
                trip_cnt = trip_cnt + 1;
                trips_tally++;
                log_append(stamp, KIND_TIMEOUT, elapsed);
            end else begin
                rev_cnt = rev_cnt + 1;
            end
        end
    endfunction

    function automatic status_t predict_status(logic [2:0] act, logic [31:0] stamp,
                                               logic [31:0] val, logic [7:0] idx);
        status_t r;
        int slot;
        r.code = CODE_NONE;
        r.etime = '0;
        r.earg = '0;
        case (act)
            ACT_TICK: heartbeat(stamp);
            ACT_UPDATE: begin
                upd_cnt = upd_cnt + 1;
                log_append(stamp, KIND_UPDATE, val);
            end
            ACT_REJECT: begin
                rej_cnt = rej_cnt + 1;
                log_append(stamp, KIND_REJECT, val);
            end
            ACT_PROTO_ERR: begin
                perr_cnt = perr_cnt + 1;
                log_append(stamp, KIND_PROTO_ERR, val);
            end
            ACT_READ: begin
                // Index 0 is the oldest entry; past the fill level reads nothing.
                if (int'(idx) < ring_fill) begin
                    slot = (ring_head + int'(idx)) % RING_DEPTH;
                    r.code = {1'b0, ring_kind[slot]};
                    r.etime = ring_stamp[slot];
                    r.earg = ring_arg[slot];
                end
            end
            ACT_CLEAR: wipe_state();
            default: ;
        endcase
        r.held = ring_fill[4:0];
        r.dropped = drop_cnt;
        r.revision = rev_cnt;
        r.beats = beat_cnt;
        r.healthy = wd_healthy;
        r.trips = trip_cnt;
        r.updates = upd_cnt;
        r.rejects = rej_cnt;
        r.proto_errs = perr_cnt;
        return r;
    endfunction

    // Register writes and accepted requests are both taken at the clock edge,
    // reading the values the testbench drove before it.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_wr_en) begin
                wd_timeout = cfg_wr_data;
            end
            if (s_tvalid && s_tready) begin
                pending_status.push_back(predict_status(s_tuser, s_tdata[31:0],
                                                        s_tdata[63:32], s_tdata[71:64]));
                act_tally[s_tuser]++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin
        status_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_status.size() == 0) begin
                $error("result arrived with no request outstanding");
                fail_count++;
            end else begin
                want = pending_status.pop_front();
                results_checked++;
                check_field("entries_held", 32'(want.held), 32'(m_tdata[4:0]));
                check_field("entries_dropped", want.dropped, m_tdata[36:5]);
                check_field("revision_count", want.revision, m_tdata[68:37]);
                check_field("heartbeats_seen", want.beats, m_tdata[100:69]);
                check_field("healthy", 32'(want.healthy), 32'(m_tdata[101]));
                check_field("watchdog_trip_count", want.trips, m_tdata[133:102]);
                check_field("update_count", want.updates, m_tdata[165:134]);
                check_field("rejection_count", want.rejects, m_tdata[197:166]);
                check_field("protocol_error_count", want.proto_errs, m_tdata[229:198]);
                check_field("entry_time", want.etime, m_tdata[261:230]);
                check_field("entry_argument", want.earg, m_tdata[293:262]);
                check_field("padding", '0, 32'(m_tdata[295:294]));
                check_field("entry_code", 32'(want.code), 32'(m_tuser));
            end
        end
    end

    // ------------------------------------------------------------------
    // Result side: random stalls, plus a long hold-off on request. The
    // hold-off is counted here so that the sender keeps pushing requests
    // into the block until it backs up and drops s_tready.
    // ------------------------------------------------------------------
    initial begin : result_sink
        int gap;
        forever begin
            @(posedge aclk);
            if (hold_off_req > 0) begin
                m_tready <= 1'b0;
                repeat (hold_off_req) @(posedge aclk);
                hold_off_req = 0;
                m_tready <= 1'b1;
            end else if (snk_idle_en && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                gap = $urandom_range(1, 8);
                repeat (gap) @(posedge aclk);
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------

    // Offers one request and returns at the edge where it is taken. Valid is
    // left high, so back-to-back calls keep the stream dense; it only drops
    // when a random gap is chosen or the sender pauses.
    task automatic send_request(input logic [2:0] act, input logic [31:0] stamp,
                                input logic [31:0] val, input logic [7:0] idx);
        int gap;
        if (src_idle_en && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 8);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= act;
        s_tdata <= {idx, val, stamp};
        do @(posedge aclk); while (!s_tready);
    endtask

    // Stops offering requests and waits until every owed result is in.
    // The list is only looked at once the predictor has run, so the last accepted
    // request is already on it by then.
    task automatic finish_outstanding();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_status.size() != 0);
    endtask

    // The timeout register is only written with the block idle.
    task automatic set_timeout(input logic [31:0] value);
        finish_outstanding();
        repeat (PIPE_CYCLES) @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        cur_timeout = value;
        timeout_settings++;
    endtask

    // Mostly heartbeats spaced around the current timeout, logged events and
    // reads at indexes up to the log depth; now and then a clear, an ignored
    // action, a wild timestamp or a read far past the end.
    task automatic send_random_request();
        int pick;
        logic [31:0] gap;
        logic [7:0] idx;
        pick = $urandom_range(0, 99);
        if (pick < 35) begin
            case ($urandom_range(0, 4))
                0: gap = '0;
                1: gap = (cur_timeout == 0) ? 32'd1 :
                         $urandom_range(1, (cur_timeout > 5000) ? 5000 : cur_timeout);
                2: gap = cur_timeout;
                3: gap = cur_timeout + 1;
                default: gap = $urandom();
            endcase
            beat_ms = beat_ms + gap;
            send_request(ACT_TICK, beat_ms, $urandom(), 8'($urandom()));
        end else if (pick < 40) begin
            send_request(ACT_TICK, $urandom(), $urandom(), 8'($urandom()));
        end else if (pick < 70) begin
            send_request((pick < 50) ? ACT_UPDATE : (pick < 60) ? ACT_REJECT : ACT_PROTO_ERR,
                         beat_ms + $urandom_range(0, 50), $urandom(), 8'($urandom()));
        end else if (pick < 96) begin
            idx = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255)) :
                                                8'($urandom_range(0, 16));
            send_request(ACT_READ, $urandom(), $urandom(), idx);
        end else if (pick < 97) begin
            send_request(ACT_CLEAR, $urandom(), $urandom(), 8'($urandom()));
        end else begin
            send_request((pick < 99) ? ACT_RSVD_A : ACT_RSVD_B,
                         $urandom(), $urandom(), 8'($urandom()));
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Runs at the reset timeout of 1000 ms: empty log, arming, a repeated
    // timestamp, on-time and late heartbeats across the 32-bit wrap, every
    // event kind with extreme arguments, reads in and out of range, the two
    // ignored actions, and a clear followed by a fresh arming.
    task automatic test_directed();
        send_request(ACT_READ, '0, '0, 8'd0);
        send_request(ACT_TICK, 32'hFFFF_FF00, '0, 8'hFF);
        send_request(ACT_TICK, 32'hFFFF_FF00, 32'hFFFF_FFFF, '0);
        send_request(ACT_TICK, 32'hFFFF_FF00 + 32'd1000, '0, '0);
        send_request(ACT_TICK, 32'hFFFF_FF00 + 32'd2001, '0, '0);
        send_request(ACT_UPDATE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF);
        send_request(ACT_REJECT, 32'h0000_0000, 32'h0000_0000, 8'h00);
        send_request(ACT_PROTO_ERR, $urandom(), $urandom(), 8'($urandom()));
        for (int i = 0; i <= 4; i++) begin
            send_request(ACT_READ, $urandom(), $urandom(), i[7:0]);
        end
        send_request(ACT_READ, '0, '0, 8'hFF);
        send_request(ACT_READ, '0, '0, 8'h80);
        send_request(ACT_RSVD_A, $urandom(), $urandom(), 8'($urandom()));
        send_request(ACT_RSVD_B, $urandom(), $urandom(), 8'($urandom()));
        send_request(ACT_CLEAR, $urandom(), $urandom(), 8'($urandom()));
        send_request(ACT_READ, '0, '0, 8'd0);
        send_request(ACT_TICK, 32'h0000_0000, '0, '0);
        send_request(ACT_TICK, 32'h0000_0000, '0, '0);
        send_request(ACT_TICK, 32'd1001, '0, '0);
        beat_ms = 32'd1001;
    endtask

    // With a zero timeout each timestamp after arming trips, so the ring overflows
    // quickly; then every age position and the first one past the end is read.
    task automatic test_log_wrap();
        set_timeout(32'd0);
        send_request(ACT_CLEAR, '0, '0, '0);
        for (int i = 0; i < 20; i++) begin
            beat_ms = beat_ms + $urandom_range(1, 20);
            if (i % 3 == 0) begin
                send_request(ACT_TICK, beat_ms, $urandom(), 8'($urandom()));
            end else begin
                send_request((i % 3 == 1) ? ACT_UPDATE : ACT_PROTO_ERR,
                             beat_ms, $urandom(), 8'($urandom()));
            end
        end
        for (int i = 0; i <= RING_DEPTH; i++) begin
            send_request(ACT_READ, $urandom(), $urandom(), i[7:0]);
        end
    endtask

    // The largest timeout never trips; a timeout of one trips on a gap of two.
    task automatic test_timeout_extremes();
        set_timeout(32'hFFFF_FFFF);
        beat_ms = beat_ms + 32'hFFFF_FFFF;
        send_request(ACT_TICK, beat_ms, '0, '0);
        beat_ms = beat_ms + 32'h8000_0000;
        send_request(ACT_TICK, beat_ms, '0, '0);
        set_timeout(32'd1);
        beat_ms = beat_ms + 32'd1;
        send_request(ACT_TICK, beat_ms, '0, '0);
        send_request(ACT_TICK, beat_ms, '0, '0);
        beat_ms = beat_ms + 32'd2;
        send_request(ACT_TICK, beat_ms, '0, '0);
        send_request(ACT_READ, '0, '0, 8'd0);
    endtask

    // Several timeout settings, each with a block of mixed random traffic.
    task automatic test_random_traffic();
        logic [31:0] limits [4];
        limits[0] = $urandom_range(1, 100);
        limits[1] = $urandom_range(500, 5000);
        limits[2] = $urandom();
        limits[3] = 32'hFFFF_FFFE;
        for (int p = 0; p < 4; p++) begin
            set_timeout(limits[p]);
            repeat (100) send_random_request();
        end
    endtask

    // The result side holds off for a long stretch while requests keep
    // coming, so the block fills up and stalls its input.
    task automatic test_backpressure();
        src_idle_en = 1'b0;
        hold_off_req = HOLD_OFF_CYCLES;
        repeat (24) send_random_request();
        src_idle_en = 1'b1;
    endtask

    // The sender pauses until every result is back, then resumes.
    task automatic test_pause_and_resume();
        finish_outstanding();
        repeat (10) send_random_request();
    endtask

    // Final stretch with both sides always ready.
    task automatic test_back_to_back();
        src_idle_en = 1'b0;
        snk_idle_en = 1'b0;
        set_timeout($urandom_range(0, 2000));
        repeat (60) send_random_request();
    endtask

    initial begin : main
        for (int i = 0; i < 8; i++) act_tally[i] = 0;
        wd_timeout = TIMEOUT_RESET;
        wipe_state();

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_log_wrap();
        test_timeout_extremes();
        test_random_traffic();
        test_backpressure();
        test_pause_and_resume();
        test_back_to_back();

        // Let anything stray come out before the verdict.
        finish_outstanding();
        repeat (PIPE_CYCLES * 4) @(posedge aclk);
        if (pending_status.size() != 0) begin
            $error("%0d results never arrived", pending_status.size());
            fail_count++;
        end

        $display("Run covered %0d ticks, %0d logged events, %0d reads, %0d clears, %0d ignored",
                 act_tally[ACT_TICK],
                 act_tally[ACT_UPDATE] + act_tally[ACT_REJECT] + act_tally[ACT_PROTO_ERR],
                 act_tally[ACT_READ], act_tally[ACT_CLEAR],
                 act_tally[ACT_RSVD_A] + act_tally[ACT_RSVD_B]);
        $display("with %0d watchdog trips, %0d log overwrites, %0d timeout settings, %0d checked",
                 trips_tally, drops_tally, timeout_settings, results_checked);
        if (fail_count == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule
